@@ hdl/wmtc_pkg.sv @@
// Shared types, constants and state codes for the weighted majority top-k counter.
`default_nettype none
package wmtc_pkg;

    // Sizing
    localparam int MAX_ITEMS      = 1024;
    localparam int VALUE_BITS     = 31;
    localparam int ADDR_BITS      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int COUNT_BITS     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_BITS       = VALUE_BITS + ADDR_BITS;

    // Fixed field widths of the command and result beats
    localparam int INDEX_BITS     = 10;
    localparam int NEW_VALUE_BITS = 31;
    localparam int TOP_COUNT_BITS = 11;

    // Command kinds
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [INDEX_BITS-1:0]       item_index;
        logic [NEW_VALUE_BITS-1:0]   new_value;
    } cmd_t;

    typedef struct packed {
        logic [TOP_COUNT_BITS-1:0]   top_count;
        logic                        unreachable;
    } result_t;

    // One write port and one read port request toward a value store
    typedef struct packed {
        logic                        we;
        logic [ADDR_BITS-1:0]        waddr;
        logic [VALUE_BITS-1:0]       wdata;
        logic [ADDR_BITS-1:0]        raddr;
    } mem_req_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_OLD_WAIT,
        ST_REM,
        ST_INS_START,
        ST_INS_STEP,
        ST_INS_PUT,
        ST_QRY_START,
        ST_QRY_STEP
    } state_t;

endpackage
`default_nettype wire

@@ hdl/wmtc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module wmtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/wmtc_ctrl.sv @@
// Sequencer: sorted insert, removal, prefix walk, count and total registers.
`default_nettype none
module wmtc_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire wmtc_pkg::cmd_t                      cmd,
    output logic                                     busy,
    output logic                                     done,
    output wmtc_pkg::result_t                        result,
    output wmtc_pkg::mem_req_t                       idx_req,
    output wmtc_pkg::mem_req_t                       sort_req,
    input  wire logic [wmtc_pkg::VALUE_BITS-1:0]     idx_rdata,
    input  wire logic [wmtc_pkg::VALUE_BITS-1:0]     sort_rdata
);

    localparam int AB = wmtc_pkg::ADDR_BITS;
    localparam int CB = wmtc_pkg::COUNT_BITS;
    localparam int VB = wmtc_pkg::VALUE_BITS;
    localparam int SB = wmtc_pkg::SUM_BITS;
    localparam logic [CB-1:0] ONE = CB'(1);

    wmtc_pkg::state_t     state_reg, state_next;
    logic [CB-1:0]        count_reg, count_next;
    logic [SB-1:0]        total_reg, total_next;
    logic                 done_reg, done_next;
    wmtc_pkg::result_t    result_reg, result_next;
    logic                 upd_reg, upd_next;
    logic [AB-1:0]        idx_reg, idx_next;
    logic [VB-1:0]        val_reg, val_next;
    logic [VB-1:0]        old_reg, old_next;
    logic [CB-1:0]        ptr_reg, ptr_next;
    logic                 found_reg, found_next;
    logic [SB-1:0]        target_reg, target_next;
    logic [SB-1:0]        acc_reg, acc_next;
    logic [CB-1:0]        taken_reg, taken_next;
    logic                 ins_fin;
    logic [SB-1:0]        acc_sum;
    logic [CB-1:0]        taken_inc;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmtc_pkg::ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        upd_reg    <= upd_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        old_reg    <= old_next;
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        target_reg <= target_next;
        acc_reg    <= acc_next;
        taken_reg  <= taken_next;
    end

    assign acc_sum   = acc_reg + SB'(sort_rdata);
    assign taken_inc = taken_reg + ONE;

    // Next state, memory requests and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        upd_next    = upd_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        old_next    = old_reg;
        ptr_next    = ptr_reg;
        found_next  = found_reg;
        target_next = target_reg;
        acc_next    = acc_reg;
        taken_next  = taken_reg;
        idx_req     = '0;
        sort_req    = '0;
        ins_fin     = 1'b0;

        unique case (state_reg)
            wmtc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    upd_next = (cmd.kind == wmtc_pkg::KIND_UPDATE);
                    val_next = cmd.new_value[VB-1:0];
                    idx_next = AB'(cmd.item_index);
                    unique case (cmd.kind)
                        wmtc_pkg::KIND_APPEND:
                        begin
                            if (count_reg < CB'(wmtc_pkg::MAX_ITEMS))
                            begin
                                ptr_next   = count_reg;
                                state_next = wmtc_pkg::ST_INS_START;
                            end
                        end
                        wmtc_pkg::KIND_QUERY:
                        begin
                            state_next = wmtc_pkg::ST_QRY_START;
                        end
                        wmtc_pkg::KIND_UPDATE:
                        begin
                            if (32'(cmd.item_index) < 32'(count_reg))
                            begin
                                state_next = wmtc_pkg::ST_OLD_RD;
                            end
                            else
                            begin
                                state_next = wmtc_pkg::ST_QRY_START;
                            end
                        end
                        wmtc_pkg::KIND_NONE:
                        begin
                            state_next = wmtc_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            state_next = wmtc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the value being replaced
            wmtc_pkg::ST_OLD_RD:
            begin
                idx_req.raddr = idx_reg;
                state_next    = wmtc_pkg::ST_OLD_WAIT;
            end

            wmtc_pkg::ST_OLD_WAIT:
            begin
                old_next       = idx_rdata;
                total_next     = total_reg - SB'(idx_rdata);
                sort_req.raddr = '0;
                ptr_next       = '0;
                found_next     = 1'b0;
                state_next     = wmtc_pkg::ST_REM;
            end

            // Scan up for the old value, then shift the rest down by one
            wmtc_pkg::ST_REM:
            begin
                if (found_reg)
                begin
                    sort_req.we    = 1'b1;
                    sort_req.waddr = AB'(ptr_reg - ONE);
                    sort_req.wdata = sort_rdata;
                end
                else if (sort_rdata == old_reg)
                begin
                    found_next = 1'b1;
                end
                if (ptr_reg == count_reg - ONE)
                begin
                    count_next = count_reg - ONE;
                    state_next = wmtc_pkg::ST_INS_START;
                end
                else
                begin
                    sort_req.raddr = AB'(ptr_reg + ONE);
                    ptr_next       = ptr_reg + ONE;
                end
            end

            // Insert: walk down from the top, shifting larger entries up
            wmtc_pkg::ST_INS_START:
            begin
                if (!upd_reg)
                begin
                    idx_req.we    = 1'b1;
                    idx_req.waddr = AB'(count_reg);
                    idx_req.wdata = val_reg;
                end
                if (ptr_reg == '0)
                begin
                    sort_req.we    = 1'b1;
                    sort_req.waddr = '0;
                    sort_req.wdata = val_reg;
                    ins_fin        = 1'b1;
                end
                else
                begin
                    sort_req.raddr = AB'(ptr_reg - ONE);
                    state_next     = wmtc_pkg::ST_INS_STEP;
                end
            end

            wmtc_pkg::ST_INS_STEP:
            begin
                sort_req.we    = 1'b1;
                sort_req.waddr = AB'(ptr_reg);
                if (sort_rdata > val_reg)
                begin
                    sort_req.wdata = sort_rdata;
                    ptr_next       = ptr_reg - ONE;
                    if (ptr_reg == ONE)
                    begin
                        state_next = wmtc_pkg::ST_INS_PUT;
                    end
                    else
                    begin
                        sort_req.raddr = AB'(ptr_reg - CB'(2));
                    end
                end
                else
                begin
                    sort_req.wdata = val_reg;
                    ins_fin        = 1'b1;
                end
            end

            wmtc_pkg::ST_INS_PUT:
            begin
                sort_req.we    = 1'b1;
                sort_req.waddr = AB'(ptr_reg);
                sort_req.wdata = val_reg;
                ins_fin        = 1'b1;
            end

            // Query setup: zero total answers at once
            wmtc_pkg::ST_QRY_START:
            begin
                if (total_reg == '0)
                begin
                    result_next.top_count   = wmtc_pkg::TOP_COUNT_BITS'(count_reg);
                    result_next.unreachable = 1'b1;
                    done_next               = 1'b1;
                    state_next              = wmtc_pkg::ST_IDLE;
                end
                else
                begin
                    target_next    = (total_reg >> 1) + SB'(1);
                    acc_next       = '0;
                    taken_next     = '0;
                    sort_req.raddr = AB'(count_reg - ONE);
                    ptr_next       = count_reg - ONE;
                    state_next     = wmtc_pkg::ST_QRY_STEP;
                end
            end

            // Prefix walk from the largest entry down
            wmtc_pkg::ST_QRY_STEP:
            begin
                acc_next   = acc_sum;
                taken_next = taken_inc;
                if ((acc_sum >= target_reg) || (ptr_reg == '0))
                begin
                    result_next.top_count   = wmtc_pkg::TOP_COUNT_BITS'(taken_inc);
                    result_next.unreachable = 1'b0;
                    done_next               = 1'b1;
                    state_next              = wmtc_pkg::ST_IDLE;
                end
                else
                begin
                    sort_req.raddr = AB'(ptr_reg - ONE);
                    ptr_next       = ptr_reg - ONE;
                end
            end

            default:
            begin
                state_next = wmtc_pkg::ST_IDLE;
            end
        endcase

        // Close an insert: bookkeeping, index store for updates
        if (ins_fin)
        begin
            count_next = count_reg + ONE;
            total_next = total_next + SB'(val_reg);
            if (upd_reg)
            begin
                idx_req.we    = 1'b1;
                idx_req.waddr = idx_reg;
                idx_req.wdata = val_reg;
                state_next    = wmtc_pkg::ST_QRY_START;
            end
            else
            begin
                state_next = wmtc_pkg::ST_IDLE;
            end
        end
    end

    assign busy   = (state_reg != wmtc_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_done_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == wmtc_pkg::ST_QRY_START
                   || $past(state_reg) == wmtc_pkg::ST_QRY_STEP))
        else $error("result beat without a query");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(wmtc_pkg::MAX_ITEMS))
        else $error("item count above capacity");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wmtc_pkg::ST_IDLE) |-> (!sort_req.we && !idx_req.we))
        else $error("store write while idle");

    a_reached_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.unreachable) |-> (result_reg.top_count != '0))
        else $error("reached target with zero entries");

endmodule
`default_nettype wire

@@ hdl/weighted_majority_topk_count_core.sv @@
// Top level: index-ordered and sorted value stores around the sequencer.
//
//  channel  | ports                  | beat marked by     | direction
//  ---------+------------------------+--------------------+----------
//  command  | start, busy, cmd       | start && !busy     | in
//  result   | done, result           | done (one cycle)   | out
//
// Append: the insert walk passes each stored entry larger than the new value.
// Query: the prefix walk runs from the largest entry down (at most item count entries).
// Update: a removal scan over every stored entry, then an insert and a query.
// All walks run one entry per cycle on the single read port of the sorted store.
// Reset clears state, count, total and the done flag only; stores need no clearing. The result has no stall.
`default_nettype none
module weighted_majority_topk_count_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire wmtc_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output wmtc_pkg::result_t      result
);

    wmtc_pkg::mem_req_t                 idx_req;
    wmtc_pkg::mem_req_t                 sort_req;
    logic [wmtc_pkg::VALUE_BITS-1:0]    idx_rdata;
    logic [wmtc_pkg::VALUE_BITS-1:0]    sort_rdata;

    // Sequencer
    wmtc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .idx_req    (idx_req),
        .sort_req   (sort_req),
        .idx_rdata  (idx_rdata),
        .sort_rdata (sort_rdata)
    );

    // Values in index order
    wmtc_ram #(
        .WIDTH (wmtc_pkg::VALUE_BITS),
        .DEPTH (wmtc_pkg::MAX_ITEMS)
    ) u_idx_ram (
        .clk   (clk),
        .we    (idx_req.we),
        .waddr (idx_req.waddr),
        .wdata (idx_req.wdata),
        .raddr (idx_req.raddr),
        .rdata (idx_rdata)
    );

    // Values in ascending order
    wmtc_ram #(
        .WIDTH (wmtc_pkg::VALUE_BITS),
        .DEPTH (wmtc_pkg::MAX_ITEMS)
    ) u_sort_ram (
        .clk   (clk),
        .we    (sort_req.we),
        .waddr (sort_req.waddr),
        .wdata (sort_req.wdata),
        .raddr (sort_req.raddr),
        .rdata (sort_rdata)
    );

endmodule
`default_nettype wire
